[hw/rtl/crp_pkg.sv]
// Shared constants, types and codes of the Catmull-Rom path evaluator.
package crp_pkg;

  // Table size and field formats.
  localparam int MAX_POINTS  = 32;
  localparam int COORD_W     = 16;
  localparam int T_W         = 15;
  localparam int T_FRAC_BITS = 10;
  localparam int SEG_W       = T_W - T_FRAC_BITS;
  localparam int GUARD_BITS  = 16;

  // Table addressing.
  localparam int PTR_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int IDX_W = ((SEG_W > CNT_W) ? SEG_W : CNT_W) + 2;

  // Datapath widths: coefficients and Horner accumulators.
  localparam int COEF_W = COORD_W + 6;
  localparam int ACC_W  = COORD_W + GUARD_BITS + 7;

  // Operation codes of an input item.
  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_EVAL   = 2'd2
  } crp_op_e;

  // Horner step index: which coefficient is added after the multiply.
  typedef enum logic [1:0] {
    STEP_C2 = 2'd0,
    STEP_C1 = 2'd1,
    STEP_C0 = 2'd2
  } crp_step_e;

  // Control from the sequencer to the per-axis datapath.
  typedef struct packed {
    logic      load;
    logic      step;
    crp_step_e sel;
  } crp_ctrl_t;

endpackage

[hw/rtl/crp_in_if.sv]
// Input channel: operation item with point coordinates and curve parameter.
interface crp_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           operation;
  logic signed [crp_pkg::COORD_W-1:0]   x_coord;
  logic signed [crp_pkg::COORD_W-1:0]   y_coord;
  logic [crp_pkg::T_W-1:0]              t_value;

  modport source (output valid, operation, x_coord, y_coord, t_value, input ready);
  modport sink   (input valid, operation, x_coord, y_coord, t_value, output ready);
endinterface

[hw/rtl/crp_out_if.sv]
// Output channel: curve position, tangent and status flags.
interface crp_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [crp_pkg::COORD_W-1:0] pos_x;
  logic signed [crp_pkg::COORD_W-1:0] pos_y;
  logic signed [crp_pkg::COORD_W-1:0] tan_x;
  logic signed [crp_pkg::COORD_W-1:0] tan_y;
  logic                               finished;
  logic                               empty_table;
  logic                               saturated;

  modport source (output valid, pos_x, pos_y, tan_x, tan_y, finished, empty_table,
                  saturated, input ready);
  modport sink   (input valid, pos_x, pos_y, tan_x, tan_y, finished, empty_table,
                  saturated, output ready);
endinterface

[hw/rtl/catmull_rom_path_evaluator_unit.sv]
// Catmull-Rom path evaluator: control point table and spline evaluation sequencer.
//
// Usage: items arrive on in_i (valid/ready). An append item stores (x, y) at the
// end of a 32-entry point table; an append to a full table is dropped. A clear item
// empties the table. Neither produces a result. An evaluate item reads the four
// neighboring points of segment t >> 10 from the single-port point memory, one
// read per cycle, then runs three Horner steps on both axes and delivers one
// result item on out_o with position, tangent and the finished, empty_table and
// saturated flags. The result register is loaded after four memory reads, one
// coefficient load and three dependent multiply-add steps, from the final state
// once the register is free; the next item is accepted after that. An evaluate
// on an empty table goes straight to the final state and loads zeros with
// empty_table set.
// The result sits in an output register; while the receiver stalls, new append
// and clear items are still accepted, and a following evaluate waits in its final
// state until the register is free. Reset empties the table and drops any item in
// flight; the table contents themselves are not cleared.
module catmull_rom_path_evaluator_unit (
  input logic clk_i,
  input logic rst_ni,
  crp_in_if.sink    in_i,
  crp_out_if.source out_o
);
  import crp_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_READ = 5'b00010,
    ST_LOAD = 5'b00100,
    ST_STEP = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [CNT_W-1:0]       count_q;
  logic [1:0]             rd_k_q;
  logic [1:0]             step_q;
  logic [SEG_W-1:0]       seg_q;
  logic [T_FRAC_BITS-1:0] u_q;
  logic                   empty_q;

  logic                   accept;
  logic                   mem_we, mem_re;
  logic [PTR_W-1:0]       mem_addr, rd_addr;
  logic [2*COORD_W-1:0]   mem [MAX_POINTS];
  logic [2*COORD_W-1:0]   rdata_q;

  logic signed [COORD_W-1:0] px_q [3];
  logic signed [COORD_W-1:0] py_q [3];

  logic signed [IDX_W-1:0] idx, last;
  logic                    out_free, finished;
  crp_ctrl_t               ctrl;

  logic signed [COORD_W-1:0] pos_x, pos_y, tan_x, tan_y;
  logic                      sat_x, sat_y;

  logic                      out_valid_q;
  logic signed [COORD_W-1:0] pos_x_q, pos_y_q, tan_x_q, tan_y_q;
  logic                      finished_q, empty_out_q, sat_q;

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  // Clamp the neighbor index of the current read to the table ends.
  always_comb begin
    idx  = $signed(IDX_W'(seg_q)) + $signed(IDX_W'(rd_k_q)) - IDX_W'(1);
    last = $signed(IDX_W'(count_q)) - IDX_W'(1);
    if (idx < 0) begin
      rd_addr = '0;
    end else if (idx > last) begin
      rd_addr = last[PTR_W-1:0];
    end else begin
      rd_addr = idx[PTR_W-1:0];
    end
    finished = $signed(IDX_W'(seg_q)) >= last;
  end

  // Single memory port: appends write in idle, neighbor reads issue in the read state.
  always_comb begin
    mem_we   = accept && (in_i.operation == OP_APPEND) &&
               (count_q < CNT_W'(MAX_POINTS));
    mem_re   = (state_q == ST_READ);
    mem_addr = mem_re ? rd_addr : count_q[PTR_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= {in_i.y_coord, in_i.x_coord};
    end
    if (mem_re) begin
      rdata_q <= mem[mem_addr];
    end
  end

  // Points a, b and c shift in as they return; d is taken straight from the read data.
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_READ) && (rd_k_q != 2'd0)) begin
      px_q[0] <= px_q[1];
      px_q[1] <= px_q[2];
      px_q[2] <= $signed(rdata_q[COORD_W-1:0]);
      py_q[0] <= py_q[1];
      py_q[1] <= py_q[2];
      py_q[2] <= $signed(rdata_q[2*COORD_W-1:COORD_W]);
    end
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (in_i.operation == OP_EVAL)) begin
          state_d = (count_q == '0) ? ST_DONE : ST_READ;
        end
      end
      ST_READ: begin
        if (rd_k_q == 2'd3) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_d = ST_STEP;
      end
      ST_STEP: begin
        if (step_q == 2'(STEP_C0)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Sequencer registers and table fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      rd_k_q  <= '0;
      step_q  <= '0;
      empty_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (mem_we) begin
        count_q <= count_q + CNT_W'(1);
      end else if (accept && (in_i.operation == OP_CLEAR)) begin
        count_q <= '0;
      end
      if (accept && (in_i.operation == OP_EVAL)) begin
        empty_q <= (count_q == '0);
      end
      rd_k_q <= (state_q == ST_READ) ? rd_k_q + 2'd1 : 2'd0;
      step_q <= (state_q == ST_STEP) ? step_q + 2'd1 : 2'd0;
    end
  end

  // Segment and fraction of the evaluate item.
  always_ff @(posedge clk_i) begin
    if (accept && (in_i.operation == OP_EVAL)) begin
      seg_q <= in_i.t_value[T_W-1:T_FRAC_BITS];
      u_q   <= in_i.t_value[T_FRAC_BITS-1:0];
    end
  end

  // Datapath control.
  always_comb begin
    ctrl.load = (state_q == ST_LOAD);
    ctrl.step = (state_q == ST_STEP);
    ctrl.sel  = crp_step_e'(step_q);
  end

  crp_axis u_axis_x (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .pa_i   (px_q[0]),
    .pb_i   (px_q[1]),
    .pc_i   (px_q[2]),
    .pd_i   ($signed(rdata_q[COORD_W-1:0])),
    .u_i    (u_q),
    .pos_o  (pos_x),
    .tan_o  (tan_x),
    .sat_o  (sat_x)
  );

  crp_axis u_axis_y (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .pa_i   (py_q[0]),
    .pb_i   (py_q[1]),
    .pc_i   (py_q[2]),
    .pd_i   ($signed(rdata_q[2*COORD_W-1:COORD_W])),
    .u_i    (u_q),
    .pos_o  (pos_y),
    .tan_o  (tan_y),
    .sat_o  (sat_y)
  );

  // Output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_DONE) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload; an empty table gives zeros.
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_DONE) && out_free) begin
      pos_x_q     <= empty_q ? '0 : pos_x;
      pos_y_q     <= empty_q ? '0 : pos_y;
      tan_x_q     <= empty_q ? '0 : tan_x;
      tan_y_q     <= empty_q ? '0 : tan_y;
      finished_q  <= !empty_q && finished;
      empty_out_q <= empty_q;
      sat_q       <= !empty_q && (sat_x || sat_y);
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.pos_x       = pos_x_q;
  assign out_o.pos_y       = pos_y_q;
  assign out_o.tan_x       = tan_x_q;
  assign out_o.tan_y       = tan_y_q;
  assign out_o.finished    = finished_q;
  assign out_o.empty_table = empty_out_q;
  assign out_o.saturated   = sat_q;

  // The fill count never passes the table size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_POINTS))
    else $error("point count exceeds table size");

  // An evaluate on a non-empty table starts the neighbor reads.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (in_i.operation == OP_EVAL) && (count_q != '0) |=> state_q == ST_READ)
    else $error("evaluate did not start neighbor reads");

  // A result is only raised from the final sequencer state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_DONE)
    else $error("result raised outside final state");

  // A write and a read never share the memory port.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("memory port conflict");

endmodule

[hw/rtl/crp_axis.sv]
// One coordinate axis: spline coefficients, Horner accumulators and output rounding.
module crp_axis (
  input  logic                               clk_i,
  input  crp_pkg::crp_ctrl_t                 ctrl_i,
  input  logic signed [crp_pkg::COORD_W-1:0] pa_i,
  input  logic signed [crp_pkg::COORD_W-1:0] pb_i,
  input  logic signed [crp_pkg::COORD_W-1:0] pc_i,
  input  logic signed [crp_pkg::COORD_W-1:0] pd_i,
  input  logic [crp_pkg::T_FRAC_BITS-1:0]    u_i,
  output logic signed [crp_pkg::COORD_W-1:0] pos_o,
  output logic signed [crp_pkg::COORD_W-1:0] tan_o,
  output logic                               sat_o
);
  import crp_pkg::*;

  localparam int PROD_W = ACC_W + T_FRAC_BITS + 1;
  localparam int RND_W  = ACC_W - GUARD_BITS - 1;

  logic signed [COEF_W-1:0] ea, eb, ec, ed;
  logic signed [COEF_W-1:0] c3, c2, c1, c0, c3x3, c2x2;
  logic signed [COEF_W-1:0] c2_q, c1_q, c0_q;
  logic signed [COEF_W-1:0] add_pos, add_tan;
  logic signed [ACC_W-1:0]  acc_pos_q, acc_pos_d, acc_tan_q, acc_tan_d;
  logic signed [PROD_W-1:0] u_ext, prod_pos, prod_tan, shr_pos, shr_tan;
  logic                     sat_pos, sat_tan;

  // Coefficients of the uniform Catmull-Rom basis, scaled by two.
  always_comb begin
    ea   = COEF_W'(pa_i);
    eb   = COEF_W'(pb_i);
    ec   = COEF_W'(pc_i);
    ed   = COEF_W'(pd_i);
    c3   = ed - ea + ((eb - ec) <<< 1) + (eb - ec);
    c2   = (ea <<< 1) - ((eb <<< 2) + eb) + (ec <<< 2) - ed;
    c1   = ec - ea;
    c0   = eb <<< 1;
    c3x3 = (c3 <<< 1) + c3;
    c2x2 = c2_q <<< 1;
  end

  // Coefficient added after each multiply by u.
  always_comb begin
    add_pos = c2_q;
    add_tan = c2x2;
    case (ctrl_i.sel)
      STEP_C2: begin
        add_pos = c2_q;
        add_tan = c2x2;
      end
      STEP_C1: begin
        add_pos = c1_q;
        add_tan = c1_q;
      end
      STEP_C0: begin
        add_pos = c0_q;
        add_tan = '0;
      end
      default: begin
        add_pos = '0;
        add_tan = '0;
      end
    endcase
  end

  // Multiply by u, floor the shift, add the next coefficient.
  always_comb begin
    u_ext     = PROD_W'($signed({1'b0, u_i}));
    prod_pos  = PROD_W'(acc_pos_q) * u_ext;
    prod_tan  = PROD_W'(acc_tan_q) * u_ext;
    shr_pos   = prod_pos >>> T_FRAC_BITS;
    shr_tan   = prod_tan >>> T_FRAC_BITS;
    acc_pos_d = $signed(shr_pos[ACC_W-1:0]) + (ACC_W'(add_pos) <<< GUARD_BITS);
    if (ctrl_i.sel == STEP_C0) begin
      acc_tan_d = acc_tan_q;
    end else begin
      acc_tan_d = $signed(shr_tan[ACC_W-1:0]) + (ACC_W'(add_tan) <<< GUARD_BITS);
    end
  end

  // Accumulators and stored coefficients.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      acc_pos_q <= ACC_W'(c3) <<< GUARD_BITS;
      acc_tan_q <= ACC_W'(c3x3) <<< GUARD_BITS;
      c2_q      <= c2;
      c1_q      <= c1;
      c0_q      <= c0;
    end else if (ctrl_i.step) begin
      acc_pos_q <= acc_pos_d;
      acc_tan_q <= acc_tan_d;
    end
  end

  // Halve, drop guard bits rounding half up, and clip to the coordinate range.
  function automatic logic [COORD_W:0] round_clip(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] rnd;
    logic [RND_W-1:0]        r;
    logic [RND_W-COORD_W:0]  hi;
    logic                    ovf;
    rnd = acc + (ACC_W'(1) <<< GUARD_BITS);
    rnd = rnd >>> (GUARD_BITS + 1);
    r   = rnd[RND_W-1:0];
    hi  = r[RND_W-1:COORD_W-1];
    ovf = !((&hi) || (~|hi));
    if (ovf) begin
      return {1'b1, r[RND_W-1], {(COORD_W-1){!r[RND_W-1]}}};
    end
    return {1'b0, r[COORD_W-1:0]};
  endfunction

  logic [COORD_W:0] pos_rc, tan_rc;

  always_comb begin
    pos_rc  = round_clip(acc_pos_q);
    tan_rc  = round_clip(acc_tan_q);
    pos_o   = $signed(pos_rc[COORD_W-1:0]);
    tan_o   = $signed(tan_rc[COORD_W-1:0]);
    sat_pos = pos_rc[COORD_W];
    sat_tan = tan_rc[COORD_W];
    sat_o   = sat_pos | sat_tan;
  end

endmodule

[bench/tb_catmull_rom_path_evaluator_unit.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the Catmull-Rom path evaluator: builds paths, evaluates them, compares.

// One result item of the evaluator.
typedef struct packed {
  logic signed [crp_pkg::COORD_W-1:0] pos_x;
  logic signed [crp_pkg::COORD_W-1:0] pos_y;
  logic signed [crp_pkg::COORD_W-1:0] tan_x;
  logic signed [crp_pkg::COORD_W-1:0] tan_y;
  logic                               finished;
  logic                               empty_table;
  logic                               saturated;
} curve_res_t;

// Mirrors the point table and predicts the curve point of every accepted evaluate item.
class curve_scoreboard;
  logic [31:0] points [crp_pkg::MAX_POINTS];
  int          num_points;
  curve_res_t  curve_due [$];
  int          errors;

  function new();
    num_points = 0;
    errors     = 0;
  endfunction

  // Rounds to nearest with ties up, drops guard bits and the final halving, then clips.
  function logic signed [15:0] round_clip(longint acc, inout bit sat);
    longint r;
    r = (acc + (longint'(1) <<< crp_pkg::GUARD_BITS)) >>> (crp_pkg::GUARD_BITS + 1);
    if (r > 32767) begin
      r   = 32767;
      sat = 1'b1;
    end else if (r < -32768) begin
      r   = -32768;
      sat = 1'b1;
    end
    return r[15:0];
  endfunction

  // Horner evaluation of position and tangent along one axis.
  function void eval_axis(longint a, longint b, longint c, longint d, longint u,
                          output logic signed [15:0] pos, output logic signed [15:0] slope,
                          inout bit sat);
    longint c3, c2, c1, c0, acc, one;
    one = longint'(1) <<< crp_pkg::GUARD_BITS;
    c3  = -a + 3 * b - 3 * c + d;
    c2  = 2 * a - 5 * b + 4 * c - d;
    c1  = c - a;
    c0  = 2 * b;

    // Each step floors the product back to the guard-bit scale.
    acc = c3 * one;
    acc = ((acc * u) >>> crp_pkg::T_FRAC_BITS) + c2 * one;
    acc = ((acc * u) >>> crp_pkg::T_FRAC_BITS) + c1 * one;
    acc = ((acc * u) >>> crp_pkg::T_FRAC_BITS) + c0 * one;
    pos = round_clip(acc, sat);

    acc = 3 * c3 * one;
    acc = ((acc * u) >>> crp_pkg::T_FRAC_BITS) + 2 * c2 * one;
    acc = ((acc * u) >>> crp_pkg::T_FRAC_BITS) + c1 * one;
    slope = round_clip(acc, sat);
  endfunction

  function curve_res_t predict_curve(logic [crp_pkg::T_W-1:0] t);
    curve_res_t res;
    longint     px [4];
    longint     py [4];
    longint     u;
    int         seg, idx, k;
    bit         sat;
    res = '0;
    sat = 1'b0;
    if (num_points == 0) begin
      res.empty_table = 1'b1;
      return res;
    end
    seg = int'(t >> crp_pkg::T_FRAC_BITS);
    u   = t[crp_pkg::T_FRAC_BITS-1:0];

    // Fetch the four neighbors, clamped to the ends of the table.
    for (k = 0; k < 4; k++) begin
      idx = seg + k - 1;
      if (idx < 0) idx = 0;
      if (idx > num_points - 1) idx = num_points - 1;
      px[k] = $signed(points[idx][15:0]);
      py[k] = $signed(points[idx][31:16]);
    end
    eval_axis(px[0], px[1], px[2], px[3], u, res.pos_x, res.tan_x, sat);
    eval_axis(py[0], py[1], py[2], py[3], u, res.pos_y, res.tan_y, sat);
    res.finished  = (seg >= num_points - 1);
    res.saturated = sat;
    return res;
  endfunction

  // Applies one accepted input item to the mirrored table.
  function void note_item(logic [1:0] op, logic [15:0] x, logic [15:0] y,
                          logic [crp_pkg::T_W-1:0] t);
    case (op)
      crp_pkg::OP_APPEND: begin
        if (num_points < crp_pkg::MAX_POINTS) begin
          points[num_points] = {y, x};
          num_points++;
        end
      end
      crp_pkg::OP_CLEAR: num_points = 0;
      crp_pkg::OP_EVAL:  curve_due = {curve_due, predict_curve(t)};
      default: ;
    endcase
  endfunction

  function void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // Compares one accepted result item with the oldest prediction.
  function void check_curve(curve_res_t got);
    curve_res_t want;
    if (curve_due.size() == 0) begin
      $error("result item arrived with no evaluation pending");
      errors++;
      return;
    end
    want = curve_due.pop_front();
    check_field("pos_x", want.pos_x, got.pos_x);
    check_field("pos_y", want.pos_y, got.pos_y);
    check_field("tan_x", want.tan_x, got.tan_x);
    check_field("tan_y", want.tan_y, got.tan_y);
    check_field("finished", want.finished, got.finished);
    check_field("empty_table", want.empty_table, got.empty_table);
    check_field("saturated", want.saturated, got.saturated);
  endfunction
endclass

module tb_catmull_rom_path_evaluator_unit;
  import crp_pkg::*;

  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 20;
  localparam int PHASE_ITEMS   = 350;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef enum int {COORD_ANY, COORD_EXTREME, COORD_NEAR} coord_mode_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  crp_in_if  in_i ();
  crp_out_if out_o ();

  curve_scoreboard sb = new();

  int tx_idle_pct = 9;
  int rx_idle_pct = 70;
  int hold_req    = 0;
  int items_sent  = 0;
  int path_len    = 0;

  // 4 ns clock.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  catmull_rom_path_evaluator_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .out_o  (out_o)
  );

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  initial begin : receiver
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    out_o.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_o.ready <= 1'b0;
      end else begin
        out_o.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Both handshakes are observed at the clock edge.
  always @(posedge clk_i) begin : monitor
    curve_res_t got;
    if (rst_ni) begin
      if (in_i.valid && in_i.ready)
        sb.note_item(in_i.operation, in_i.x_coord, in_i.y_coord, in_i.t_value);
      if (out_o.valid && out_o.ready) begin
        got = '{pos_x: out_o.pos_x, pos_y: out_o.pos_y, tan_x: out_o.tan_x,
                tan_y: out_o.tan_y, finished: out_o.finished,
                empty_table: out_o.empty_table, saturated: out_o.saturated};
        sb.check_curve(got);
      end
    end
  end

  // Ends the run when no item moves on either side for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_i.valid && in_i.ready) || (out_o.valid && out_o.ready)) quiet = 0;
      else quiet++;
    end
    $display("tb_catmull_rom_path_evaluator_unit: done, errors");
    $finish;
  end

  // Offers one item after a random gap and waits until it is accepted.
  task automatic send_item(logic [1:0] op, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                           logic [T_W-1:0] t);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_i.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_i.valid     <= 1'b1;
    in_i.operation <= op;
    in_i.x_coord   <= x;
    in_i.y_coord   <= y;
    in_i.t_value   <= t;
    @(posedge clk_i);
    while (!in_i.ready) @(posedge clk_i);

    // Dropped appends and the unused code do no work and are not counted.
    if (op == OP_APPEND) begin
      if (path_len < MAX_POINTS) begin
        path_len++;
        items_sent++;
      end
    end else if (op == OP_CLEAR) begin
      path_len = 0;
      items_sent++;
    end else if (op == OP_EVAL) begin
      items_sent++;
    end
  endtask

  // Idles the input until every pending evaluation has been returned.
  task automatic wait_drained();
    in_i.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.curve_due.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [COORD_W-1:0] pick_coord(coord_mode_e mode);
    case (mode)
      COORD_ANY: return COORD_W'($urandom);
      COORD_EXTREME: begin
        case ($urandom_range(3))
          0:       return 16'h8000;
          1:       return 16'h7FFF;
          2:       return 16'h0000;
          default: return 16'hFFFF;
        endcase
      end
      default: return COORD_W'($urandom_range(400) - 200);
    endcase
  endfunction

  // Mostly a segment inside the path, sometimes anywhere; fraction often at its ends.
  function automatic logic [T_W-1:0] pick_t(int n);
    logic [SEG_W-1:0]       seg;
    logic [T_FRAC_BITS-1:0] frac;
    if (n == 0 || $urandom_range(9) == 0) seg = SEG_W'($urandom);
    else seg = SEG_W'($urandom_range(n - 1));
    case ($urandom_range(7))
      0:       frac = '0;
      1:       frac = '1;
      default: frac = T_FRAC_BITS'($urandom);
    endcase
    return {seg, frac};
  endfunction

  // Mostly whole paths followed by evaluations on them, with some noise items.
  task automatic run_random(int target);
    int          stop_at;
    int          n;
    coord_mode_e mode;
    stop_at = items_sent + target;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 85) begin
        if ($urandom_range(4) != 0)
          send_item(OP_CLEAR, COORD_W'($urandom), COORD_W'($urandom), T_W'($urandom));
        n    = ($urandom_range(9) == 0) ? $urandom_range(36, 9) : $urandom_range(8, 1);
        mode = coord_mode_e'($urandom_range(2));
        repeat (n) send_item(OP_APPEND, pick_coord(mode), pick_coord(mode), T_W'($urandom));
        repeat ($urandom_range(10, 1))
          send_item(OP_EVAL, COORD_W'($urandom), COORD_W'($urandom), pick_t(path_len));
      end else begin
        repeat ($urandom_range(4, 1))
          send_item(2'($urandom), COORD_W'($urandom), COORD_W'($urandom), T_W'($urandom));
      end
    end
  endtask

  initial begin
    in_i.valid     <= 1'b0;
    in_i.operation <= OP_CLEAR;
    in_i.x_coord   <= '0;
    in_i.y_coord   <= '0;
    in_i.t_value   <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table, unused code, full-scale zigzag, clamped and end segments.
    send_item(OP_EVAL, '0, '0, '0);
    send_item(OP_UNUSED, 16'h7FFF, 16'h8000, 15'h7FFF);
    send_item(OP_CLEAR, '0, '0, '0);
    send_item(OP_APPEND, 16'h8000, 16'h7FFF, '0);
    send_item(OP_APPEND, 16'h7FFF, 16'h8000, '0);
    send_item(OP_APPEND, 16'h8000, 16'h7FFF, '0);
    send_item(OP_APPEND, 16'h7FFF, 16'h8000, '0);
    send_item(OP_EVAL, '0, '0, 15'h0000);
    send_item(OP_EVAL, '0, '0, {5'd1, 10'd512});
    send_item(OP_EVAL, '0, '0, {5'd2, 10'h3FF});
    send_item(OP_EVAL, '0, '0, {5'd3, 10'd0});
    send_item(OP_EVAL, '0, '0, 15'h7FFF);
    send_item(OP_UNUSED, 16'h1234, 16'h5678, 15'h0400);
    send_item(OP_EVAL, 16'hFFFF, 16'hFFFF, 15'h0400);
    send_item(OP_CLEAR, 16'hFFFF, 16'hFFFF, 15'h7FFF);
    send_item(OP_EVAL, '0, '0, 15'h0200);
    send_item(OP_APPEND, 16'h7FFF, 16'h8000, 15'h7FFF);
    send_item(OP_EVAL, '0, '0, 15'h0200);
    send_item(OP_EVAL, '0, '0, 15'h7FFF);

    // Slow receiver.
    run_random(PHASE_ITEMS);
    wait_drained();

    // Slow sender.
    tx_idle_pct = 70;
    rx_idle_pct <= 9;
    run_random(PHASE_ITEMS);
    wait_drained();

    // No idling; a long output stall first, so the block backs up into its input.
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    hold_req    <= hold_req + 1;
    send_item(OP_CLEAR, '0, '0, '0);
    repeat (6) send_item(OP_APPEND, pick_coord(COORD_ANY), pick_coord(COORD_ANY), '0);
    repeat (8) send_item(OP_EVAL, '0, '0, pick_t(path_len));
    wait_drained();
    run_random(PHASE_ITEMS);
    wait_drained();

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.curve_due.size() != 0) begin
      $error("%0d evaluations never returned a result", sb.curve_due.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("tb_catmull_rom_path_evaluator_unit: done, clean");
    end else begin
      $display("tb_catmull_rom_path_evaluator_unit: done, errors");
    end
    $finish;
  end

endmodule
